// ===== hdl/swsfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swsfd_pkg;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_TIMEOUT = 2'd1,
      STATUS_ERROR   = 2'd2
   } status_type;

   typedef enum logic {
      ACTION_TICK  = 1'b0,
      ACTION_START = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      CSR_BIT_ONE_THRESHOLD = 2'd0,
      CSR_TIMEOUT_TICKS     = 2'd1,
      CSR_MIN_CHANGES       = 2'd2
   } csr_index_type;

   typedef struct packed {
      status_type         status;
      logic [15:0]        humidity_tenths;
      logic signed [15:0] temperature_tenths;
   } frame_result_type;

   localparam logic [6:0] TOTAL_CHANGES     = 7'd85;
   localparam logic [6:0] DATA_START_CHANGE = 7'd4;
   localparam logic [6:0] CHANGES_MAX       = 7'd127;
   localparam logic [5:0] FRAME_BITS_LEN    = 6'd40;
   localparam logic [7:0] TICKS_MAX         = 8'd255;

   localparam logic [7:0] RESET_BIT_ONE_THRESHOLD = 8'd9;
   localparam logic [7:0] RESET_TIMEOUT_TICKS     = 8'd250;
   localparam logic [6:0] RESET_MIN_CHANGES       = 7'd80;

endpackage

`default_nettype wire

// ===== hdl/swsfd_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface swsfd_req_if;
   logic valid;
   logic ready;
   logic action;
   logic line_level;

   modport source (output valid, output action, output line_level, input ready);
   modport sink (input valid, input action, input line_level, output ready);
endinterface

`default_nettype wire

// ===== hdl/swsfd_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface swsfd_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [15:0]        humidity_tenths;
   logic signed [15:0] temperature_tenths;

   modport source (output valid, output status, output humidity_tenths,
                   output temperature_tenths, input ready);
   modport sink (input valid, input status, input humidity_tenths,
                 input temperature_tenths, output ready);
endinterface

`default_nettype wire

// ===== hdl/swsfd_frame_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swsfd_frame_check import swsfd_pkg::*; (
   input  wire logic [39:0]     frame,
   input  wire logic [5:0]      bit_count,
   output frame_result_type     result
);

   logic [7:0]  byte0;
   logic [7:0]  byte1;
   logic [7:0]  byte2;
   logic [7:0]  byte3;
   logic [7:0]  byte4;
   logic [7:0]  checksum;
   logic [15:0] magnitude;

   assign byte0     = frame[39:32];
   assign byte1     = frame[31:24];
   assign byte2     = frame[23:16];
   assign byte3     = frame[15:8];
   assign byte4     = frame[7:0];
   assign checksum  = byte0 + byte1 + byte2 + byte3;
   assign magnitude = {1'b0, byte2[6:0], byte3};

   always_comb begin
      if ((bit_count >= FRAME_BITS_LEN) && (byte4 == checksum)) begin
         result.status          = STATUS_OK;
         result.humidity_tenths = {byte0, byte1};
         if (byte2[7]) begin
            result.temperature_tenths = 16'(-magnitude);
         end else begin
            result.temperature_tenths = magnitude;
         end
      end else begin
         result.status             = STATUS_ERROR;
         result.humidity_tenths    = '0;
         result.temperature_tenths = '0;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/single_wire_sensor_frame_decoder_top.sv =====
// Single-wire sensor frame decoder.
// The req_bus channel carries one transaction per line sample: action selects
// a tick (with line_level) or the start of a new measurement. The rsp_bus
// channel carries one transaction when a measurement ends: status, humidity
// and signed temperature in tenths.
// The csr_ port writes the bit threshold, the timeout length and the minimum
// change count; the user must write it only while the block is idle, and the
// block itself does not enforce this. An accepted transaction is held in an
// input register, where the run state is updated and the end of the frame is
// checked; a result is then registered in the output register. One transaction
// is accepted in every cycle while the receiver does not stall; the rate is set
// by the single input register feeding the single output register.
// Reset clears the run state, loads the register defaults and empties both
// registers. When the receiver stalls, a result waits in the output register
// and the transaction in the input register waits behind it, whether or not it
// gives a result; the input side stalls once the input register is full and
// resumes in the cycle in which the waiting result is taken.
`timescale 1ns / 1ps
`default_nettype none

module single_wire_sensor_frame_decoder_top import swsfd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   swsfd_req_if.sink       req_bus,
   swsfd_rsp_if.source     rsp_bus,
   input  wire logic       csr_write_enable,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_write_data
);

   logic [7:0] threshold_ff;
   logic [7:0] timeout_ff;
   logic [6:0] min_changes_ff;

   logic req_valid_ff, req_valid_in;
   logic action_ff;
   logic line_level_ff;

   logic        busy_ff, busy_in;
   logic        previous_level_ff, previous_level_in;
   logic [7:0]  level_ticks_ff, level_ticks_in;
   logic [6:0]  change_count_ff, change_count_in;
   logic [5:0]  bit_count_ff, bit_count_in;
   logic [39:0] frame_bits_ff, frame_bits_in;

   logic             rsp_valid_ff, rsp_valid_in;
   frame_result_type rsp_data_ff, rsp_data_in;

   logic             advance;
   logic             produce;
   logic [7:0]       ticks_sat;
   logic [6:0]       changes_sat;
   frame_result_type check_result;

   assign advance       = req_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= RESET_BIT_ONE_THRESHOLD;
         timeout_ff     <= RESET_TIMEOUT_TICKS;
         min_changes_ff <= RESET_MIN_CHANGES;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BIT_ONE_THRESHOLD: threshold_ff   <= csr_write_data;
            CSR_TIMEOUT_TICKS:     timeout_ff     <= csr_write_data;
            CSR_MIN_CHANGES:       min_changes_ff <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_bus.valid && req_bus.ready) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         action_ff     <= req_bus.action;
         line_level_ff <= req_bus.line_level;
      end
   end

   assign ticks_sat   = (level_ticks_ff == TICKS_MAX) ? TICKS_MAX : level_ticks_ff + 8'd1;
   assign changes_sat = (change_count_ff == CHANGES_MAX) ? CHANGES_MAX
                                                         : change_count_ff + 7'd1;

   always_comb begin
      busy_in           = busy_ff;
      previous_level_in = previous_level_ff;
      level_ticks_in    = level_ticks_ff;
      change_count_in   = change_count_ff;
      bit_count_in      = bit_count_ff;
      frame_bits_in     = frame_bits_ff;
      produce           = 1'b0;
      rsp_data_in       = check_result;
      if (advance) begin
         if (action_ff == ACTION_START) begin
            busy_in           = 1'b1;
            previous_level_in = 1'b1;
            level_ticks_in    = '0;
            change_count_in   = '0;
            bit_count_in      = '0;
            frame_bits_in     = '0;
         end else if (busy_ff) begin
            if (line_level_ff == previous_level_ff) begin
               level_ticks_in = ticks_sat;
               if (ticks_sat >= timeout_ff) begin
                  busy_in = 1'b0;
                  produce = 1'b1;
                  if (change_count_ff < min_changes_ff) begin
                     rsp_data_in.status             = STATUS_TIMEOUT;
                     rsp_data_in.humidity_tenths    = '0;
                     rsp_data_in.temperature_tenths = '0;
                  end
               end
            end else begin
               previous_level_in = line_level_ff;
               if ((change_count_ff >= DATA_START_CHANGE) && !line_level_ff
                   && (bit_count_ff < FRAME_BITS_LEN)) begin
                  frame_bits_in = {frame_bits_ff[38:0], (level_ticks_ff >= threshold_ff)};
                  bit_count_in  = bit_count_ff + 6'd1;
               end
               level_ticks_in  = '0;
               change_count_in = changes_sat;
               if (changes_sat >= TOTAL_CHANGES) begin
                  busy_in = 1'b0;
                  produce = 1'b1;
               end
            end
         end
      end
   end

   swsfd_frame_check u_frame_check (
      .frame     (frame_bits_in),
      .bit_count (bit_count_in),
      .result    (check_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff           <= 1'b0;
         previous_level_ff <= 1'b1;
         level_ticks_ff    <= '0;
         change_count_ff   <= '0;
         bit_count_ff      <= '0;
         frame_bits_ff     <= '0;
      end else begin
         busy_ff           <= busy_in;
         previous_level_ff <= previous_level_in;
         level_ticks_ff    <= level_ticks_in;
         change_count_ff   <= change_count_in;
         bit_count_ff      <= bit_count_in;
         frame_bits_ff     <= frame_bits_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.status             = rsp_data_ff.status;
   assign rsp_bus.humidity_tenths    = rsp_data_ff.humidity_tenths;
   assign rsp_bus.temperature_tenths = rsp_data_ff.temperature_tenths;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status != STATUS_OK)
         |-> (rsp_data_ff.humidity_tenths == '0) && (rsp_data_ff.temperature_tenths == '0))
      else $error("Failed result carries non-zero readings.");

   assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= FRAME_BITS_LEN)
      else $error("Frame bit count has passed forty.");

   assert property (@(posedge clock) disable iff (reset)
      produce |-> busy_ff && (action_ff == ACTION_TICK) ##1 !busy_ff && rsp_valid_ff)
      else $error("Result produced outside a running measurement.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |-> !produce)
      else $error("Result overwritten while the receiver stalls.");

endmodule

`default_nettype wire

// ===== tb/single_wire_sensor_frame_decoder_top_tb.sv =====
`timescale 1ns / 1ps

module single_wire_sensor_frame_decoder_top_tb;
   import swsfd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_500_000;
   localparam int LONG_HOLD = 400;

   typedef struct packed {
      action_type act;
      logic       lvl;
   } line_sample_type;

   typedef enum {SEQ_FULL, SEQ_TRUNCATED, SEQ_RESTART, SEQ_NOISE} sequence_kind_type;

   class frame_scoreboard;
      logic [7:0]       one_threshold;
      logic [7:0]       timeout_len;
      logic [6:0]       min_changes;
      bit               running;
      logic             prev_level;
      logic [7:0]       level_ticks;
      logic [6:0]       change_count;
      logic [5:0]       bit_count;
      logic [39:0]      frame_bits;
      frame_result_type expected_frames[$];
      int               errors;
      int               results_checked;

      function new();
         one_threshold = RESET_BIT_ONE_THRESHOLD;
         timeout_len = RESET_TIMEOUT_TICKS;
         min_changes = RESET_MIN_CHANGES;
         running = 1'b0;
         errors = 0;
         results_checked = 0;
         clear_run();
      endfunction

      function void clear_run();
         prev_level = 1'b1;
         level_ticks = '0;
         change_count = '0;
         bit_count = '0;
         frame_bits = '0;
      endfunction

      function void set_register(csr_index_type idx, logic [7:0] data);
         case (idx)
            CSR_BIT_ONE_THRESHOLD: one_threshold = data;
            CSR_TIMEOUT_TICKS: timeout_len = data;
            CSR_MIN_CHANGES: min_changes = data[6:0];
            default: ;
         endcase
      endfunction

      function int frames_pending();
         return expected_frames.size();
      endfunction

      function void close_frame();
         logic [7:0]       b0, b1, b2, b3, b4, sum;
         logic [15:0]      temp;
         frame_result_type r;
         b0 = frame_bits[39:32];
         b1 = frame_bits[31:24];
         b2 = frame_bits[23:16];
         b3 = frame_bits[15:8];
         b4 = frame_bits[7:0];
         sum = b0 + b1 + b2 + b3;
         running = 1'b0;
         if (bit_count >= FRAME_BITS_LEN && b4 == sum) begin
            temp = {1'b0, b2[6:0], b3};
            if (b2[7])
               temp = -temp;
            r.status = STATUS_OK;
            r.humidity_tenths = {b0, b1};
            r.temperature_tenths = temp;
         end else begin
            r.status = STATUS_ERROR;
            r.humidity_tenths = '0;
            r.temperature_tenths = '0;
         end
         expected_frames.push_back(r);
      endfunction

      // Returns 1 when the transaction is not simply ignored by an idle decoder.
      function bit decode_sample(action_type act, logic lvl);
         frame_result_type r;
         if (act == ACTION_START) begin
            clear_run();
            running = 1'b1;
            return 1'b1;
         end
         if (!running)
            return 1'b0;
         if (lvl == prev_level) begin
            if (level_ticks != TICKS_MAX)
               level_ticks++;
            if (level_ticks >= timeout_len) begin
               if (change_count < min_changes) begin
                  running = 1'b0;
                  r.status = STATUS_TIMEOUT;
                  r.humidity_tenths = '0;
                  r.temperature_tenths = '0;
                  expected_frames.push_back(r);
               end else begin
                  close_frame();
               end
            end
            return 1'b1;
         end
         prev_level = lvl;
         if (change_count >= DATA_START_CHANGE && lvl == 1'b0 && bit_count < FRAME_BITS_LEN) begin
            frame_bits = {frame_bits[38:0], level_ticks >= one_threshold};
            bit_count++;
         end
         level_ticks = '0;
         if (change_count != CHANGES_MAX)
            change_count++;
         if (change_count >= TOTAL_CHANGES)
            close_frame();
         return 1'b1;
      endfunction

      function void check_frame(logic [1:0] status, logic [15:0] humidity,
                                logic signed [15:0] temperature);
         frame_result_type want;
         results_checked++;
         if (expected_frames.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: status %0d humidity %0d temperature %0d",
                        status, humidity, temperature);
            return;
         end
         want = expected_frames.pop_front();
         if (status !== want.status || humidity !== want.humidity_tenths ||
             temperature !== want.temperature_tenths) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: expected status %0d humidity %0d temperature %0d, ",
                         "got status %0d humidity %0d temperature %0d"},
                        want.status, want.humidity_tenths, want.temperature_tenths,
                        status, humidity, temperature);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [7:0]  csr_write_data;
   bit          hold_request;
   int          burst_left;
   int          useful_items;
   int unsigned cycle_count;

   frame_scoreboard sb;

   swsfd_req_if req_if();
   swsfd_rsp_if rsp_if();

   single_wire_sensor_frame_decoder_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_if),
      .rsp_bus          (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("single_wire_sensor_frame_decoder_top test failed");
      $finish;
   end

   // The receiver stalls at random; a requested long hold is counted down here.
   initial begin
      int stall_left, run_left, r;
      stall_left = 0;
      run_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = LONG_HOLD;
            run_left = 0;
         end
         if (stall_left == 0 && run_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 25)
               stall_left = $urandom_range(1, 3);
            else if (r < 30)
               stall_left = $urandom_range(10, 40);
            else if (r < 35)
               run_left = $urandom_range(100, 300);
            else
               run_left = $urandom_range(1, 12);
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            run_left--;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_frame(rsp_if.status, rsp_if.humidity_tenths, rsp_if.temperature_tenths);
   end

   task automatic send_item(input action_type act, input logic lvl);
      int gap, r;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 2) begin
            burst_left = $urandom_range(50, 300);
            gap = 0;
         end else if (r < 55) begin
            gap = 0;
         end else if (r < 88) begin
            gap = $urandom_range(1, 3);
         end else if (r < 97) begin
            gap = $urandom_range(4, 10);
         end else begin
            gap = $urandom_range(15, 30);
         end
      end
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.action <= act;
      req_if.line_level <= lvl;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      if (sb.decode_sample(act, lvl))
         useful_items++;
   endtask

   task automatic write_register(input csr_index_type idx, input logic [7:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.set_register(idx, data);
   endtask

   task automatic set_config(input logic [7:0] thr, input logic [7:0] tmo,
                             input logic [6:0] minch);
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.frames_pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_register(CSR_BIT_ONE_THRESHOLD, thr);
      write_register(CSR_TIMEOUT_TICKS, tmo);
      write_register(CSR_MIN_CHANGES, {1'b0, minch});
   endtask

   function automatic void add_run(ref line_sample_type seq[$], ref int run_first[$],
                                   input logic lvl, input int n);
      int cap;
      cap = (sb.timeout_len == 0) ? 1 : int'(sb.timeout_len);
      if (n > cap)
         n = cap;
      run_first.push_back(seq.size());
      repeat (n) seq.push_back('{ACTION_TICK, lvl});
   endfunction

   // A reply of the usual shape: three preamble levels, forty bits as high pulses
   // whose length against the threshold sets the bit, then a closing pulse.
   function automatic void build_frame(ref line_sample_type seq[$], ref int run_first[$]);
      logic [7:0]  fb[0:4];
      logic [39:0] word;
      int          thr, hl;
      thr = sb.one_threshold;
      for (int i = 0; i < 4; i++) begin
         if ($urandom_range(0, 4) == 0)
            case ($urandom_range(0, 3))
               0: fb[i] = 8'h00;
               1: fb[i] = 8'hff;
               2: fb[i] = 8'h7f;
               default: fb[i] = 8'h80;
            endcase
         else
            fb[i] = 8'($urandom_range(0, 255));
      end
      fb[4] = fb[0] + fb[1] + fb[2] + fb[3];
      if ($urandom_range(0, 4) == 0)
         fb[4] = fb[4] ^ 8'($urandom_range(1, 255));
      word = {fb[0], fb[1], fb[2], fb[3], fb[4]};
      seq.delete();
      run_first.delete();
      seq.push_back('{ACTION_START, 1'($urandom_range(0, 1))});
      add_run(seq, run_first, 1'b0, $urandom_range(1, 3));
      add_run(seq, run_first, 1'b1, $urandom_range(1, 3));
      add_run(seq, run_first, 1'b0, $urandom_range(1, 3));
      for (int i = 39; i >= 0; i--) begin
         if (word[i])
            hl = thr + 1 + $urandom_range(0, 1);
         else
            hl = (thr == 0) ? 1 : $urandom_range(1, thr);
         add_run(seq, run_first, 1'b1, hl);
         add_run(seq, run_first, 1'b0, $urandom_range(1, 3));
      end
      add_run(seq, run_first, 1'b1, $urandom_range(1, 3));
      add_run(seq, run_first, 1'b0, 1);
   endfunction

   task automatic send_sequence(input sequence_kind_type kind, input int last_run);
      line_sample_type seq[$];
      line_sample_type tail[$];
      int              runs[$];
      int              cut, hold, n;
      logic            lvl;
      build_frame(seq, runs);
      case (kind)
         SEQ_TRUNCATED: begin
            if (last_run >= 84 && $urandom_range(0, 2) == 0)
               cut = runs[$urandom_range(78, 84)] + 1;
            else
               cut = runs[$urandom_range(0, last_run)] + 1;
            while (seq.size() > cut) void'(seq.pop_back());
            lvl = seq[cut - 1].lvl;
            hold = ((sb.timeout_len == 0) ? 1 : int'(sb.timeout_len)) + $urandom_range(0, 3);
            repeat (hold) seq.push_back('{ACTION_TICK, lvl});
         end
         SEQ_RESTART: begin
            cut = $urandom_range(2, seq.size() - 1);
            while (seq.size() > cut) void'(seq.pop_back());
            build_frame(tail, runs);
            foreach (tail[i]) seq.push_back(tail[i]);
         end
         SEQ_NOISE: begin
            seq.delete();
            n = $urandom_range(4, 30);
            repeat (n)
               seq.push_back('{($urandom_range(0, 5) == 0) ? ACTION_START : ACTION_TICK,
                               1'($urandom_range(0, 1))});
         end
         default: ;
      endcase
      foreach (seq[i]) send_item(seq[i].act, seq[i].lvl);
   endtask

   initial begin
      int                thr, tmo, r;
      sequence_kind_type kind;
      sb = new();
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.action = ACTION_TICK;
      req_if.line_level = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_BIT_ONE_THRESHOLD;
      csr_write_data = '0;
      hold_request = 1'b0;
      burst_left = 0;
      useful_items = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Idle ticks, a start while busy, and short runs under the reset settings and under timeouts of zero and one.
      send_item(ACTION_TICK, 1'b0);
      send_item(ACTION_TICK, 1'b1);
      send_item(ACTION_START, 1'b0);
      send_item(ACTION_TICK, 1'b0);
      send_item(ACTION_TICK, 1'b1);
      send_item(ACTION_START, 1'b1);
      send_item(ACTION_TICK, 1'b1);
      send_item(ACTION_TICK, 1'b0);
      set_config(8'd9, 8'd0, 7'd80);
      send_item(ACTION_START, 1'b1);
      send_item(ACTION_TICK, 1'b1);
      set_config(8'd9, 8'd1, 7'd0);
      send_item(ACTION_START, 1'b0);
      send_item(ACTION_TICK, 1'b0);
      send_item(ACTION_TICK, 1'b0);
      set_config(8'd0, 8'd1, 7'd127);
      send_item(ACTION_START, 1'b1);
      send_item(ACTION_TICK, 1'b0);
      send_item(ACTION_TICK, 1'b1);
      send_item(ACTION_TICK, 1'b1);

      set_config(RESET_BIT_ONE_THRESHOLD, RESET_TIMEOUT_TICKS, RESET_MIN_CHANGES);
      send_sequence(SEQ_FULL, 84);

      while (useful_items < 500) begin
         thr = $urandom_range(0, 4);
         tmo = ((thr + 2 > 3) ? thr + 2 : 3) + $urandom_range(0, 5);
         set_config(8'(thr), 8'(tmo), 7'($urandom_range(0, 127)));
         repeat (2) begin
            r = $urandom_range(0, 99);
            if (r < 55)
               kind = SEQ_FULL;
            else if (r < 80)
               kind = SEQ_TRUNCATED;
            else if (r < 90)
               kind = SEQ_RESTART;
            else
               kind = SEQ_NOISE;
            send_sequence(kind, 84);
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 5)) send_item(ACTION_TICK, 1'($urandom_range(0, 1)));
         end
      end

      set_config(8'd0, 8'd1, 7'd0);
      send_sequence(SEQ_FULL, 84);
      send_sequence(SEQ_TRUNCATED, 84);
      send_sequence(SEQ_RESTART, 84);
      send_sequence(SEQ_NOISE, 84);

      set_config(8'd5, 8'd0, 7'd40);
      send_sequence(SEQ_FULL, 84);
      send_sequence(SEQ_TRUNCATED, 84);
      send_sequence(SEQ_NOISE, 84);
      send_sequence(SEQ_NOISE, 84);

      set_config(8'd255, 8'd255, 7'd127);
      repeat (2) send_sequence(SEQ_TRUNCATED, 4);
      set_config(8'd255, 8'd255, 7'd0);
      send_sequence(SEQ_TRUNCATED, 4);

      // Results pile up behind a long receiver stall until the input side backs up.
      set_config(8'd3, 8'd1, 7'd127);
      hold_request = 1'b1;
      repeat (40) begin
         send_item(ACTION_START, 1'b0);
         send_item(ACTION_TICK, 1'b1);
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.frames_pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.frames_pending() == 0)
         $display("single_wire_sensor_frame_decoder_top test passed");
      else
         $display("single_wire_sensor_frame_decoder_top test failed");
      $finish;
   end

endmodule
